// File: src/qesb_pkg.sv
// Shared types, codes and constants for the quadrature encoder speed bucket block.
package qesb_pkg;

   // Width of the adjusted value and its limits
   localparam int VALUE_WIDTH = 16;
   // Signed working width for value arithmetic
   localparam int EXT_WIDTH   = VALUE_WIDTH + 2;
   localparam int BUCKET_W    = 8;
   localparam int TIME_W      = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Pin pattern at rest, where a detent is counted
   localparam logic [1:0] IDLE_PINS = 2'b11;
   // Span thresholds for the bucket weights
   localparam int SPAN_FAST = 100;
   localparam int SPAN_MID  = 30;

   // Transaction kinds
   localparam logic [1:0] KIND_PIN    = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERY_FAST = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST      = 2'd2;

   typedef logic signed [1:0] step_type;

   // Quadrature transition table, indexed by {previous pins, current pins}
   function automatic step_type step_of(input logic [3:0] idx);
      step_type s;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
         default: s = 2'sd0;
      endcase
      return s;
   endfunction

endpackage

// File: src/quadrature_encoder_speed_buckets_top.sv
// Top level of the quadrature encoder decoder with speed buckets and value adjustment.
// Every transaction is registered on entry and processed from the input register, so the
// block takes one transaction per clock unless stalled; a report result is registered in
// the result register. Only the single result register holds the input back: while a
// result is stalled, a report waiting in the input register stalls the request side;
// pin samples and millisecond ticks keep flowing, as they produce no result.
module quadrature_encoder_speed_buckets_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [1:0]                          req_pins,
   input  logic [qesb_pkg::VALUE_WIDTH-1:0]    req_value,
   input  logic [qesb_pkg::VALUE_WIDTH-1:0]    req_low_limit,
   input  logic [qesb_pkg::VALUE_WIDTH-1:0]    req_high_limit,
   input  logic                                req_wrap,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [qesb_pkg::VALUE_WIDTH-1:0]    rsp_new_value,
   output logic                                rsp_changed,
   output logic signed [7:0]                   rsp_shift,
   input  logic                                csr_write,
   input  logic [qesb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qesb_pkg::CSR_DATA_W-1:0]     csr_data
);
   import qesb_pkg::*;

   localparam int W = VALUE_WIDTH;

   // Configuration registers
   logic               dir_neg_ff;
   logic [TIME_W-1:0]  very_fast_ff;
   logic [TIME_W-1:0]  fast_ff;

   // Input register
   logic               s1_valid_ff;
   logic [1:0]         s1_kind_ff;
   logic [1:0]         s1_pins_ff;
   logic [W-1:0]       s1_value_ff;
   logic [W-1:0]       s1_lo_ff;
   logic [W-1:0]       s1_hi_ff;
   logic               s1_wrap_ff;

   // Decoder state
   logic [1:0]          last_pins_ff, last_pins_in;
   logic [7:0]          sub_ff, sub_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [TIME_W-1:0]   last_click_ff, last_click_in;
   logic [BUCKET_W-1:0] bucket_ff [3];
   logic [BUCKET_W-1:0] bucket_in [3];

   // Result register
   logic               rsp_valid_ff;
   logic [W-1:0]       new_value_ff, new_value_in;
   logic               changed_ff, changed_in;
   logic signed [7:0]  shift_ff, shift_in;

   // Handshake
   logic out_free;
   logic s1_is_report;
   logic s1_moves;
   logic req_take;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_is_report = (s1_kind_ff == KIND_REPORT);
   assign s1_moves     = s1_valid_ff && (!s1_is_report || out_free);
   assign req_stall    = s1_valid_ff && !s1_moves;
   assign req_take     = req_valid && !req_stall;

   // Pin decode
   step_type          step_raw;
   logic [7:0]        step_ext;
   logic [7:0]        sub_next;
   logic              click;
   logic [BUCKET_W-1:0] click_inc;
   logic [TIME_W-1:0] delta;

   always_comb begin
      step_raw  = step_of({last_pins_ff, s1_pins_ff});
      step_ext  = {{6{step_raw[1]}}, step_raw};
      if (dir_neg_ff) begin
         step_ext = 8'(-step_ext);
      end
      sub_next  = 8'(sub_ff + step_ext);
      click     = (s1_pins_ff == IDLE_PINS) && (sub_next != 8'd0);
      click_inc = sub_next[7] ? {BUCKET_W{1'b1}} : BUCKET_W'(1);
      delta     = TIME_W'(now_ff - last_click_ff);
   end

   // Report arithmetic
   logic [W:0]               span_ext;
   logic signed [EXT_WIDTH-1:0] span_e;
   logic                     span_neg;
   logic                     span_fast;
   logic                     span_mid;
   logic [7:0]               b0, b1, b2;
   logic [7:0]               b1w, b2w;
   logic [7:0]               shift_u;
   logic signed [EXT_WIDTH-1:0] v_e, lo_e, hi_e, sh_e, half_e, res_e;

   always_comb begin
      span_ext  = {1'b0, s1_hi_ff} - {1'b0, s1_lo_ff};
      span_e    = {span_ext[W], span_ext};
      span_neg  = span_ext[W];
      span_fast = !span_neg && (span_ext[W-1:0] > W'(SPAN_FAST));
      span_mid  = !span_neg && (span_ext[W-1:0] > W'(SPAN_MID));
      b0 = bucket_ff[0];
      b1 = bucket_ff[1];
      b2 = bucket_ff[2];
      // Weight the buckets: 1,3,6 for a wide span, 1,2,3 for a middle one
      if (span_fast) begin
         b1w = 8'(b1 + {b1[6:0], 1'b0});
         b2w = 8'({b2[6:0], 1'b0} + {b2[5:0], 2'b00});
      end else if (span_mid) begin
         b1w = {b1[6:0], 1'b0};
         b2w = 8'(b2 + {b2[6:0], 1'b0});
      end else begin
         b1w = b1;
         b2w = b2;
      end
      shift_u = 8'(b0 + b1w + b2w);

      v_e    = {2'b00, s1_value_ff};
      lo_e   = {2'b00, s1_lo_ff};
      hi_e   = {2'b00, s1_hi_ff};
      half_e = {3'b000, span_ext[W-1:1]};
      sh_e   = {{(EXT_WIDTH-8){shift_u[7]}}, shift_u};

      // Halve an oversize shift
      if (sh_e > EXT_WIDTH'(1) && sh_e >= span_e) begin
         sh_e = half_e;
      end
      if (sh_e < -EXT_WIDTH'(1) && -sh_e >= span_e) begin
         sh_e = -half_e;
      end
      res_e = v_e + sh_e;

      // Wrap or saturate, then force into range
      if (res_e < lo_e) begin
         res_e = s1_wrap_ff ? res_e + span_e : lo_e;
      end else if (res_e > hi_e) begin
         res_e = s1_wrap_ff ? res_e - span_e : hi_e;
      end
      if (res_e < lo_e) begin
         res_e = lo_e;
      end
      if (res_e > hi_e) begin
         res_e = hi_e;
      end

      shift_in = shift_u;
      if (s1_value_ff > s1_hi_ff) begin
         new_value_in = s1_hi_ff;
         changed_in   = 1'b1;
      end else if (s1_value_ff < s1_lo_ff) begin
         new_value_in = s1_lo_ff;
         changed_in   = 1'b1;
      end else if (shift_u == 8'd0) begin
         new_value_in = s1_value_ff;
         changed_in   = 1'b0;
      end else begin
         new_value_in = res_e[W-1:0];
         changed_in   = (res_e != v_e);
      end
   end

   // Next state of the decoder
   always_comb begin
      last_pins_in  = last_pins_ff;
      sub_in        = sub_ff;
      now_in        = now_ff;
      last_click_in = last_click_ff;
      for (int i = 0; i < 3; i++) begin
         bucket_in[i] = bucket_ff[i];
      end
      if (s1_moves) begin
         case (s1_kind_ff)
            KIND_PIN: begin
               last_pins_in = s1_pins_ff;
               sub_in       = sub_next;
               if (click) begin
                  sub_in        = 8'd0;
                  last_click_in = now_ff;
                  if (delta < very_fast_ff) begin
                     bucket_in[2] = BUCKET_W'(bucket_ff[2] + click_inc);
                  end else if (delta < fast_ff) begin
                     bucket_in[1] = BUCKET_W'(bucket_ff[1] + click_inc);
                  end else begin
                     bucket_in[0] = BUCKET_W'(bucket_ff[0] + click_inc);
                  end
               end
            end
            KIND_TICK: begin
               now_in = TIME_W'(now_ff + 1'b1);
            end
            KIND_REPORT: begin
               for (int i = 0; i < 3; i++) begin
                  bucket_in[i] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_neg_ff   <= 1'b0;
         very_fast_ff <= TIME_W'(50);
         fast_ff      <= TIME_W'(150);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DIRECTION: dir_neg_ff   <= csr_data[0];
            CSR_VERY_FAST: very_fast_ff <= csr_data[TIME_W-1:0];
            CSR_FAST:      fast_ff      <= csr_data[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_moves) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Input register: payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff  <= req_kind;
         s1_pins_ff  <= req_pins;
         s1_value_ff <= req_value;
         s1_lo_ff    <= req_low_limit;
         s1_hi_ff    <= req_high_limit;
         s1_wrap_ff  <= req_wrap;
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pins_ff  <= IDLE_PINS;
         sub_ff        <= 8'd0;
         now_ff        <= '0;
         last_click_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            bucket_ff[i] <= '0;
         end
      end else begin
         last_pins_ff  <= last_pins_in;
         sub_ff        <= sub_in;
         now_ff        <= now_in;
         last_click_ff <= last_click_in;
         for (int i = 0; i < 3; i++) begin
            bucket_ff[i] <= bucket_in[i];
         end
      end
   end

   // Result register: control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_moves && s1_is_report) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register: payload
   always_ff @(posedge clock) begin
      if (s1_moves && s1_is_report) begin
         new_value_ff <= new_value_in;
         changed_ff   <= changed_in;
         shift_ff     <= shift_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_value = new_value_ff;
   assign rsp_changed   = changed_ff;
   assign rsp_shift     = shift_ff;

   // A report that leaves the input register lands in the result register
   a_report_lands: assert property (@(posedge clock) disable iff (reset)
      s1_moves && s1_is_report |=> rsp_valid_ff)
      else $error("report transaction lost");

   // A report clears all buckets
   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      s1_moves && s1_is_report |=>
         (bucket_ff[0] == '0) && (bucket_ff[1] == '0) && (bucket_ff[2] == '0))
      else $error("buckets not cleared by report");

   // Resting pins leave no sub-position behind
   a_detent_clears_sub: assert property (@(posedge clock) disable iff (reset)
      s1_moves && (s1_kind_ff == KIND_PIN) && (s1_pins_ff == IDLE_PINS) |=>
         (sub_ff == 8'd0))
      else $error("sub-position left at rest");

   // Stall only while a report waits behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_is_report && rsp_valid_ff && rsp_stall)
      else $error("request stalled without cause");

endmodule

// File: bench/quadrature_encoder_speed_buckets_monitor.sv
// Channel monitor for the encoder block: tracks detent clicks and checks every report result.
`timescale 1ns / 1ps
module quadrature_encoder_speed_buckets_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [1:0]                          req_pins,
   input  logic [qesb_pkg::VALUE_WIDTH-1:0]    req_value,
   input  logic [qesb_pkg::VALUE_WIDTH-1:0]    req_low_limit,
   input  logic [qesb_pkg::VALUE_WIDTH-1:0]    req_high_limit,
   input  logic                                req_wrap,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [qesb_pkg::VALUE_WIDTH-1:0]    rsp_new_value,
   input  logic                                rsp_changed,
   input  logic signed [7:0]                   rsp_shift,
   input  logic                                csr_write,
   input  logic [qesb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qesb_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                  mismatch_total,
   output int                                  adjust_pending
);
   import qesb_pkg::*;

   localparam logic [TIME_W-1:0] RESET_VERY_FAST_MS = 16'd50;
   localparam logic [TIME_W-1:0] RESET_FAST_MS      = 16'd150;
   localparam int                SHOWN_MISMATCHES   = 10;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] new_value;
      logic                   changed;
      logic signed [7:0]      shift;
   } adjust_result_type;

   // Register copies
   logic              reverse_dir;
   logic [TIME_W-1:0] very_fast_ms;
   logic [TIME_W-1:0] fast_ms;

   // Decoder and bucket state
   logic [1:0]          prev_pins;
   logic [7:0]          sub_pos;
   logic [TIME_W-1:0]   now_ms;
   logic [TIME_W-1:0]   last_click_ms;
   logic [BUCKET_W-1:0] bucket [3];

   adjust_result_type adjust_q [$];
   int                mismatches;

   // Signed step for one pin transition; illegal jumps and repeats give none
   function automatic int quad_step(input logic [1:0] from_pins, input logic [1:0] to_pins);
      int s;
      case ({from_pins, to_pins})
         4'b0010, 4'b0100, 4'b1011, 4'b1101: s = 1;
         4'b0001, 4'b0111, 4'b1000, 4'b1110: s = -1;
         default: s = 0;
      endcase
      return s;
   endfunction

   // Advance the sub-position and count a click at the idle detent
   task automatic track_pins(input logic [1:0] pins);
      int                s;
      logic [7:0]        click;
      logic [TIME_W-1:0] interval;
      s = quad_step(prev_pins, pins);
      if (reverse_dir) begin
         s = -s;
      end
      sub_pos   = sub_pos + 8'(s);
      prev_pins = pins;
      if (prev_pins == IDLE_PINS && sub_pos != 8'd0) begin
         click    = ($signed(sub_pos) > 0) ? 8'h01 : 8'hFF;
         sub_pos  = 8'd0;
         interval = now_ms - last_click_ms;
         if (interval < very_fast_ms) begin
            bucket[2] = bucket[2] + click;
         end else if (interval < fast_ms) begin
            bucket[1] = bucket[1] + click;
         end else begin
            bucket[0] = bucket[0] + click;
         end
         last_click_ms = now_ms;
      end
   endtask

   // Weight the buckets and adjust the value within its limits
   function automatic adjust_result_type predict_adjust(
                                                     input logic [VALUE_WIDTH-1:0] value,
                                                     input logic [VALUE_WIDTH-1:0] lo_lim,
                                                     input logic [VALUE_WIDTH-1:0] hi_lim,
                                                     input logic wrap_en);
      int                v, lo, hi, span, w1, w2, sh, res;
      logic [7:0]        weighted;
      adjust_result_type r;
      v    = int'(value);
      lo   = int'(lo_lim);
      hi   = int'(hi_lim);
      span = hi - lo;
      w1   = 1;
      w2   = 1;
      if (span > SPAN_FAST) begin
         w1 = 3;
         w2 = 6;
      end else if (span > SPAN_MID) begin
         w1 = 2;
         w2 = 3;
      end
      weighted = 8'(int'(bucket[0]) + int'(bucket[1]) * w1 + int'(bucket[2]) * w2);
      r.shift  = weighted;
      if (v > hi) begin
         r.new_value = hi_lim;
         r.changed   = 1'b1;
      end else if (v < lo) begin
         r.new_value = lo_lim;
         r.changed   = 1'b1;
      end else if (weighted == 8'd0) begin
         r.new_value = value;
         r.changed   = 1'b0;
      end else begin
         sh = int'($signed(weighted));
         // halve a shift that would cross the whole range
         if (sh > 1 && sh >= span) begin
            sh = span / 2;
         end
         if (sh < -1 && -sh >= span) begin
            sh = -(span / 2);
         end
         res = v + sh;
         if (res < lo) begin
            res = wrap_en ? res + span : lo;
         end else if (res > hi) begin
            res = wrap_en ? res - span : hi;
         end
         // a degenerate range can still leave the wrapped value outside
         if (res < lo) begin
            res = lo;
         end
         if (res > hi) begin
            res = hi;
         end
         r.new_value = res[VALUE_WIDTH-1:0];
         r.changed   = (res != v);
      end
      return r;
   endfunction

   // Follow register writes and transactions on both channels
   always @(posedge clock) begin
      adjust_result_type got;
      adjust_result_type want;
      if (reset) begin
         reverse_dir   = 1'b0;
         very_fast_ms  = RESET_VERY_FAST_MS;
         fast_ms       = RESET_FAST_MS;
         prev_pins     = IDLE_PINS;
         sub_pos       = 8'd0;
         now_ms        = '0;
         last_click_ms = '0;
         foreach (bucket[i]) bucket[i] = '0;
         adjust_q.delete();
         mismatches    = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DIRECTION: reverse_dir  = csr_data[0];
               CSR_VERY_FAST: very_fast_ms = csr_data[TIME_W-1:0];
               CSR_FAST:      fast_ms      = csr_data[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_kind)
               KIND_PIN:  track_pins(req_pins);
               KIND_TICK: now_ms = now_ms + 1'b1;
               KIND_REPORT: begin
                  adjust_q.push_back(predict_adjust(req_value, req_low_limit,
                                                    req_high_limit, req_wrap));
                  foreach (bucket[i]) bucket[i] = '0;
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.new_value = rsp_new_value;
            got.changed   = rsp_changed;
            got.shift     = rsp_shift;
            if (adjust_q.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MISMATCHES) begin
                  $display("%0t: unexpected result value %0d changed %0d shift %0d",
                           $realtime, got.new_value, got.changed, got.shift);
               end
            end else begin
               want = adjust_q.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= SHOWN_MISMATCHES) begin
                     $display("%0t: result expected value %0d changed %0d shift %0d, got %0d %0d %0d",
                              $realtime, want.new_value, want.changed, want.shift,
                              got.new_value, got.changed, got.shift);
                  end
               end
            end
         end
      end
      mismatch_total <= mismatches;
      adjust_pending <= adjust_q.size();
   end

endmodule

// File: bench/quadrature_encoder_speed_buckets_top_test.sv
// Stimulus, clock, reset and verdict for the quadrature encoder speed bucket block.
`timescale 1ns / 1ps
module quadrature_encoder_speed_buckets_top_test;
   import qesb_pkg::*;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 1450;
   localparam int         PHASES       = 6;
   localparam int         IDLE_LIMIT   = 500;
   localparam int         SETTLE       = 4;
   localparam int         DRAIN_CYCLES = 8;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_kind;
   logic [1:0]             req_pins;
   logic [VALUE_WIDTH-1:0] req_value;
   logic [VALUE_WIDTH-1:0] req_low_limit;
   logic [VALUE_WIDTH-1:0] req_high_limit;
   logic                   req_wrap;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [VALUE_WIDTH-1:0] rsp_new_value;
   logic                   rsp_changed;
   logic signed [7:0]      rsp_shift;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int mismatch_total;
   int adjust_pending;
   int phase_sent;
   int idle_run = 0;
   bit no_idle  = 1'b0;

   quadrature_encoder_speed_buckets_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_pins       (req_pins),
      .req_value      (req_value),
      .req_low_limit  (req_low_limit),
      .req_high_limit (req_high_limit),
      .req_wrap       (req_wrap),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_new_value  (rsp_new_value),
      .rsp_changed    (rsp_changed),
      .rsp_shift      (rsp_shift),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   quadrature_encoder_speed_buckets_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_pins       (req_pins),
      .req_value      (req_value),
      .req_low_limit  (req_low_limit),
      .req_high_limit (req_high_limit),
      .req_wrap       (req_wrap),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_new_value  (rsp_new_value),
      .rsp_changed    (rsp_changed),
      .rsp_shift      (rsp_shift),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_total (mismatch_total),
      .adjust_pending (adjust_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int idle_cycles();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   // Present one transaction after a random gap and hold it until accepted
   task automatic send(input logic [1:0] kind, input logic [1:0] pins,
                       input logic [VALUE_WIDTH-1:0] value, input logic [VALUE_WIDTH-1:0] lo,
                       input logic [VALUE_WIDTH-1:0] hi, input logic wrap_en);
      int gap;
      gap = idle_cycles();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_kind       = kind;
      req_pins       = pins;
      req_value      = value;
      req_low_limit  = lo;
      req_high_limit = hi;
      req_wrap       = wrap_en;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      phase_sent++;
   endtask

   // Unused fields carry junk so the block is seen to ignore them
   task automatic send_pins(input logic [1:0] pins);
      send(KIND_PIN, pins, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send(KIND_TICK, 2'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 1'($urandom));
   endtask

   task automatic send_report(input logic [VALUE_WIDTH-1:0] value,
                              input logic [VALUE_WIDTH-1:0] lo,
                              input logic [VALUE_WIDTH-1:0] hi, input logic wrap_en);
      send(KIND_REPORT, 2'($urandom), value, lo, hi, wrap_en);
   endtask

   // One full detent, clockwise or counter-clockwise
   task automatic turn(input bit clockwise);
      if (clockwise) begin
         send_pins(2'd1);
         send_pins(2'd0);
         send_pins(2'd2);
         send_pins(2'd3);
      end else begin
         send_pins(2'd2);
         send_pins(2'd0);
         send_pins(2'd1);
         send_pins(2'd3);
      end
   endtask

   // Report with limits spread over the three weight bands, inverted and equal
   task automatic random_report();
      int lo, hi, v;
      lo = $urandom_range(0, 65535);
      case ($urandom_range(0, 5))
         0: hi = lo + $urandom_range(0, 30);
         1: hi = lo + $urandom_range(31, 100);
         2: hi = lo + $urandom_range(101, 3000);
         3: hi = $urandom_range(0, 65535);
         4: hi = lo;
         default: begin
            lo = 0;
            hi = 65535;
         end
      endcase
      if (hi > 65535) begin
         hi = 65535;
      end
      case ($urandom_range(0, 7))
         0: v = $urandom_range(0, 65535);
         1: v = lo;
         2: v = hi;
         3: v = (lo > 0) ? lo - 1 : 0;
         4: v = (hi < 65535) ? hi + 1 : 65535;
         default: v = (hi >= lo) ? $urandom_range(lo, hi) : $urandom_range(0, 65535);
      endcase
      send_report(16'(v), 16'(lo), 16'(hi), 1'($urandom));
   endtask

   // Change registers only once the block has drained
   task automatic write_registers(input logic reverse, input logic [15:0] very_fast,
                                  input logic [15:0] fast);
      @(negedge clock);
      req_valid = 1'b0;
      while (adjust_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = CSR_DIRECTION;
      csr_data  = {15'($urandom), reverse};
      @(negedge clock);
      csr_index = CSR_VERY_FAST;
      csr_data  = very_fast;
      @(negedge clock);
      csr_index = CSR_FAST;
      csr_data  = fast;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic apply_setting(input int phase);
      case (phase)
         1: write_registers(1'b0, 16'd2, 16'd6);
         2: write_registers(1'b1, 16'd0, 16'd0);
         3: write_registers(1'b0, 16'hFFFF, 16'hFFFF);
         4: write_registers(1'b1, 16'd4, 16'd3);
         default: write_registers(1'b0, 16'd1, 16'd12);
      endcase
   endtask

   // Mostly clean detents with tick gaps; some noise, broken turns and long spins
   task automatic random_chunk();
      int pick;
      bit cw;
      if ($urandom_range(0, 39) == 0) begin
         no_idle = ~no_idle;
      end
      pick = $urandom_range(0, 99);
      cw   = 1'($urandom);
      if (pick < 50) begin
         turn(cw);
         if ($urandom_range(0, 2) != 0) begin
            send_ticks($urandom_range(1, 12));
         end
      end else if (pick < 65) begin
         send_ticks($urandom_range(1, 12));
      end else if (pick < 78) begin
         random_report();
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 3)) send_pins(2'($urandom));
      end else if (pick < 93) begin
         // start a detent and back out of it
         send_pins(cw ? 2'd1 : 2'd2);
         if ($urandom_range(0, 1) == 1) begin
            send_pins(2'd0);
            send_pins(cw ? 2'd1 : 2'd2);
         end
         send_pins(2'd3);
      end else if (pick < 96) begin
         repeat ($urandom_range(20, 40)) turn(cw);
      end else begin
         send(KIND_UNUSED, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              1'($urandom));
      end
   endtask

   // Result side: stall a random number of cycles before each transaction
   initial begin
      int n;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         n = idle_cycles();
         repeat (n) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Drop the run when no transaction or write moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_run <= 0;
      end else if (idle_run >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_PIN;
      req_pins       = IDLE_PINS;
      req_value      = '0;
      req_low_limit  = '0;
      req_high_limit = '0;
      req_wrap       = 1'b0;
      csr_write      = 1'b0;
      csr_index      = CSR_DIRECTION;
      csr_data       = '0;
      phase_sent     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty report, clamps, inverted limits, unused kind, wraps, degenerate range
      send_report(16'd1234, 16'd0, 16'hFFFF, 1'b0);
      send_report(16'hFFFF, 16'd0, 16'd1000, 1'b1);
      send_report(16'd0, 16'd10, 16'd20, 1'b0);
      send_report(16'd500, 16'd1000, 16'd10, 1'b1);
      send_report(16'd5, 16'd1000, 16'd10, 1'b0);
      send(KIND_UNUSED, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      turn(1'b1);
      send_report(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
      send_ticks(1);
      turn(1'b0);
      send_report(16'd0, 16'd0, 16'hFFFF, 1'b0);
      send_pins(2'd1);
      send_pins(2'd3);
      turn(1'b1);
      send_report(16'd7, 16'd7, 16'd7, 1'b1);

      // Random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            apply_setting(phase);
         end
         phase_sent = 0;
         while (phase_sent < RANDOM_ITEMS / PHASES) random_chunk();
      end

      // Drain and give the verdict
      @(negedge clock);
      req_valid = 1'b0;
      while (adjust_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
